>>> rtl/core/quadrature_decoder_with_acceleration_unit_defines.svh
// ----------------------------------------------------------------------------
// qda assertion macros
// shared concurrent assertion shorthands for the encoder decoder
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DECODER_WITH_ACCELERATION_UNIT_DEFINES_SVH
`define QUADRATURE_DECODER_WITH_ACCELERATION_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define QDA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds at every edge out of reset
`define QDA_ASSERT_ALW(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

>>> rtl/core/qda_pkg.sv
// ----------------------------------------------------------------------------
// qda_pkg
// types and fixed codes of the quadrature decoder with acceleration
// ----------------------------------------------------------------------------
package qda_pkg;

  localparam int LIMIT_W = 16;
  localparam int MAG_W   = 7;
  localparam int STEP_W  = 8;
  localparam int CH_W    = 3;
  localparam int HIST_W  = 4;
  localparam int IDX_W   = 3;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // history patterns
  localparam logic [HIST_W-1:0] HIST_DOWN = 4'b1000;
  localparam logic [HIST_W-1:0] HIST_UP   = 4'b1101;

  typedef enum logic [IDX_W-1:0] {
    REG_FASTEST_LIMIT = 3'd0,
    REG_FAST_LIMIT    = 3'd1,
    REG_MEDIUM_LIMIT  = 3'd2,
    REG_SLOW_LIMIT    = 3'd3,
    REG_FASTEST_STEP  = 3'd4,
    REG_FAST_STEP     = 3'd5,
    REG_MEDIUM_STEP   = 3'd6,
    REG_SLOW_STEP     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] fastest_limit;
    logic [LIMIT_W-1:0] fast_limit;
    logic [LIMIT_W-1:0] medium_limit;
    logic [LIMIT_W-1:0] slow_limit;
    logic [MAG_W-1:0]   fastest_step;
    logic [MAG_W-1:0]   fast_step;
    logic [MAG_W-1:0]   medium_step;
    logic [MAG_W-1:0]   slow_step;
  } cfg_t;

  // one registered input word
  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] channel;
    logic            phase_a;
    logic            phase_b;
  } item_t;

  // decode result toward the output register
  typedef struct packed {
    logic              hit;
    logic [CH_W-1:0]   source_channel;
    logic [STEP_W-1:0] step;
  } result_t;

endpackage

>>> rtl/core/qda_cfg_regs.sv
// ----------------------------------------------------------------------------
// qda_cfg_regs
// threshold and step size registers with a plain write port
// ----------------------------------------------------------------------------
module qda_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [qda_pkg::IDX_W-1:0]     cfg_index,
  input  logic [qda_pkg::LIMIT_W-1:0]   cfg_data,
  output qda_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fastest_limit <= 16'd7;
      cfg.fast_limit    <= 16'd15;
      cfg.medium_limit  <= 16'd22;
      cfg.slow_limit    <= 16'd30;
      cfg.fastest_step  <= 7'd24;
      cfg.fast_step     <= 7'd16;
      cfg.medium_step   <= 7'd8;
      cfg.slow_step     <= 7'd4;
    end else if (cfg_write) begin
      unique case (qda_pkg::cfg_reg_t'(cfg_index))
        qda_pkg::REG_FASTEST_LIMIT: cfg.fastest_limit <= cfg_data;
        qda_pkg::REG_FAST_LIMIT:    cfg.fast_limit    <= cfg_data;
        qda_pkg::REG_MEDIUM_LIMIT:  cfg.medium_limit  <= cfg_data;
        qda_pkg::REG_SLOW_LIMIT:    cfg.slow_limit    <= cfg_data;
        qda_pkg::REG_FASTEST_STEP:  cfg.fastest_step  <= cfg_data[qda_pkg::MAG_W-1:0];
        qda_pkg::REG_FAST_STEP:     cfg.fast_step     <= cfg_data[qda_pkg::MAG_W-1:0];
        qda_pkg::REG_MEDIUM_STEP:   cfg.medium_step   <= cfg_data[qda_pkg::MAG_W-1:0];
        qda_pkg::REG_SLOW_STEP:     cfg.slow_step     <= cfg_data[qda_pkg::MAG_W-1:0];
      endcase
    end
  end

endmodule

>>> rtl/core/qda_decode.sv
// ----------------------------------------------------------------------------
// qda_decode
// per-channel history and step time state, step detect and magnitude pick
// ----------------------------------------------------------------------------
module qda_decode #(
  parameter int CHANNELS   = 6,
  parameter int TIME_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  qda_pkg::item_t    item,
  input  qda_pkg::cfg_t     cfg,
  output qda_pkg::result_t  result
);

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TIME_WIDTH-1:0]         tick_count;
  logic [qda_pkg::HIST_W-1:0]    phase_history  [CHANNELS];
  logic [TIME_WIDTH-1:0]         last_step_time [CHANNELS];

  logic [CHW-1:0]                ch_idx;
  logic                          ch_ok;
  logic                          is_sample;
  logic [qda_pkg::HIST_W-1:0]    hist_next;
  logic                          is_down;
  logic                          is_edge;
  logic [TIME_WIDTH-1:0]         elapsed;
  logic [qda_pkg::MAG_W-1:0]     mag;

  assign ch_idx    = CHW'(item.channel);
  assign ch_ok     = 32'(item.channel) < CHANNELS;
  assign is_sample = (item.cmd == qda_pkg::CMD_SAMPLE) && ch_ok;
  assign hist_next = {phase_history[ch_idx][1:0], item.phase_a, item.phase_b};
  assign is_down   = hist_next == qda_pkg::HIST_DOWN;
  assign is_edge   = is_down || (hist_next == qda_pkg::HIST_UP);
  // modulo subtract stays right across a counter wrap
  assign elapsed   = tick_count - last_step_time[ch_idx];

  always_comb begin
    priority if (elapsed < TIME_WIDTH'(cfg.fastest_limit)) mag = cfg.fastest_step;
    else if (elapsed < TIME_WIDTH'(cfg.fast_limit))        mag = cfg.fast_step;
    else if (elapsed < TIME_WIDTH'(cfg.medium_limit))      mag = cfg.medium_step;
    else if (elapsed < TIME_WIDTH'(cfg.slow_limit))        mag = cfg.slow_step;
    else                                                    mag = qda_pkg::MAG_W'(1);
  end

  always_comb begin
    result.hit            = is_sample && is_edge && (mag != '0);
    result.source_channel = item.channel;
    result.step           = is_down ? qda_pkg::STEP_W'(8'd0 - {1'b0, mag})
                                    : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_history[i]  <= '0;
        last_step_time[i] <= '0;
      end
    end else if (fire) begin
      if (item.cmd == qda_pkg::CMD_TICK) begin
        tick_count <= tick_count + TIME_WIDTH'(1);
      end else if (ch_ok) begin
        phase_history[ch_idx] <= hist_next;
        if (is_edge) begin
          last_step_time[ch_idx] <= tick_count;
        end
      end
    end
  end

endmodule

>>> rtl/core/quadrature_decoder_with_acceleration_unit.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_with_acceleration_unit
// multi-channel rotary encoder decoder with speed dependent step size
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_ready  | cmd, channel, phase_a, phase_b
//  output  | out_valid / out_ready| source_channel, step
//  config  | cfg_write            | cfg_index, cfg_data
//
//  one word per cycle sustained while no result stalls; a word passes the
//  input register, the decode and then the result register
//  reset clears tick counter, all channel histories and step times, and
//  loads the default thresholds and step sizes
//  a stalled result only blocks a word that itself makes a result; ticks
//  and non-stepping samples keep flowing past a waiting result
// ----------------------------------------------------------------------------
`include "quadrature_decoder_with_acceleration_unit_defines.svh"

module quadrature_decoder_with_acceleration_unit #(
  parameter int CHANNELS   = 6,
  parameter int TIME_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_write,
  input  logic [qda_pkg::IDX_W-1:0]         cfg_index,
  input  logic [qda_pkg::LIMIT_W-1:0]       cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [qda_pkg::CH_W-1:0]          channel,
  input  logic                              phase_a,
  input  logic                              phase_b,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [qda_pkg::CH_W-1:0]          source_channel,
  output logic signed [qda_pkg::STEP_W-1:0] step
);

  qda_pkg::cfg_t    cfg;
  qda_pkg::item_t   s1_item;
  logic             s1_valid;
  qda_pkg::result_t dec;
  logic             out_free;
  logic             s1_fire;

  qda_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // result slot can take a word this cycle
  assign out_free = !out_valid || out_ready;
  // held word retires unless it steps and the result slot is full
  assign s1_fire  = s1_valid && (!dec.hit || out_free);
  assign in_ready = !s1_valid || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= '{cmd: cmd, channel: channel, phase_a: phase_a, phase_b: phase_b};
    end
  end

  qda_decode #(
    .CHANNELS   (CHANNELS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (dec)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire && dec.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && dec.hit) begin
      source_channel <= dec.source_channel;
      step           <= dec.step;
    end
  end

  `QDA_ASSERT_IMP(a_step_nonzero, clk, rst, out_valid, step != '0,
    "result word with zero step")
  `QDA_ASSERT_IMP(a_src_in_range, clk, rst, out_valid, 32'(source_channel) < CHANNELS,
    "result word from a channel out of range")
  `QDA_ASSERT_IMP(a_tick_no_hit, clk, rst, s1_valid && (s1_item.cmd == qda_pkg::CMD_TICK),
    !dec.hit, "tick word decoded as a step")
  `QDA_ASSERT_IMP(a_stall_cause, clk, rst, !in_ready,
    s1_valid && dec.hit && out_valid && !out_ready, "input stalled without a full result slot")

endmodule

>>> tb/tb_quadrature_decoder_with_acceleration_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadrature_decoder_with_acceleration_unit
// self-checking bench for the multi-channel encoder decoder: drives tick and
// phase sample words under random input gaps and output stalls, keeps its
// own model of time, histories and step times, and checks every step word
// in order across several threshold and step size settings
// ----------------------------------------------------------------------------
module tb_quadrature_decoder_with_acceleration_unit;

  localparam int          CHANNELS     = 6;
  localparam int          TIME_W       = 64;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          RANDOM_WORDS = 210;
  localparam int          NUM_PHASES   = 9;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          NUM_ROWS     = 23;
  localparam int          CFG_W        = $bits(qda_pkg::cfg_t);

  // one step word as the decoder should emit it
  typedef struct packed {
    logic [qda_pkg::CH_W-1:0]          ch;
    logic signed [qda_pkg::STEP_W-1:0] value;
  } step_word_t;

  // directed row: a word, how often to send it, and an optional typed result
  typedef struct packed {
    qda_pkg::item_t word;
    logic [7:0]     reps;
    logic           fixed;
    logic           hit;
    step_word_t     result;
  } dir_row_t;

  localparam step_word_t NO_STEP = '0;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [qda_pkg::IDX_W-1:0]         cfg_index = '0;
  logic [qda_pkg::LIMIT_W-1:0]       cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic                              cmd       = qda_pkg::CMD_SAMPLE;
  logic [qda_pkg::CH_W-1:0]          channel   = '0;
  logic                              phase_a   = 1'b0;
  logic                              phase_b   = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [qda_pkg::CH_W-1:0]          source_channel;
  logic signed [qda_pkg::STEP_W-1:0] step;

  // decoder model state
  logic [TIME_W-1:0]          tick_now;
  logic [qda_pkg::HIST_W-1:0] hist_of    [CHANNELS];
  logic [TIME_W-1:0]          stepped_at [CHANNELS];
  qda_pkg::cfg_t              cfg_now;

  step_word_t  pending_steps [$];
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  // pacing of both sides
  logic        calm          = 1'b0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pace_count    = 0;

  // directed words, all under the reset settings; typed results only where
  // they follow at once from reset (zero elapsed time gives the fastest step)
  dir_row_t dir_rows [NUM_ROWS] = '{
    // fresh channel 0: 10 then 00 is a step down with no time elapsed
    '{'{qda_pkg::CMD_SAMPLE, 3'd0, 1'b1, 1'b0}, 8'd1, 1'b1, 1'b0, '{3'd0, 8'sd0}},
    '{'{qda_pkg::CMD_SAMPLE, 3'd0, 1'b0, 1'b0}, 8'd1, 1'b1, 1'b1, '{3'd0, -8'sd24}},
    // last channel: 11 then 01 is a step up
    '{'{qda_pkg::CMD_SAMPLE, 3'd5, 1'b1, 1'b1}, 8'd1, 1'b1, 1'b0, '{3'd0, 8'sd0}},
    '{'{qda_pkg::CMD_SAMPLE, 3'd5, 1'b0, 1'b1}, 8'd1, 1'b1, 1'b1, '{3'd5, 8'sd24}},
    // channels past the last one are dropped without a trace
    '{'{qda_pkg::CMD_SAMPLE, 3'd6, 1'b1, 1'b0}, 8'd1, 1'b1, 1'b0, '{3'd0, 8'sd0}},
    '{'{qda_pkg::CMD_SAMPLE, 3'd7, 1'b0, 1'b0}, 8'd1, 1'b1, 1'b0, '{3'd0, 8'sd0}},
    '{'{qda_pkg::CMD_SAMPLE, 3'd7, 1'b1, 1'b1}, 8'd1, 1'b1, 1'b0, '{3'd0, 8'sd0}},
    // ticks never produce a word, whatever rides along in the other fields
    '{'{qda_pkg::CMD_TICK,   3'd7, 1'b1, 1'b1}, 8'd1, 1'b1, 1'b0, '{3'd0, 8'sd0}},
    '{'{qda_pkg::CMD_TICK,   3'd0, 1'b0, 1'b0}, 8'd8, 1'b1, 1'b0, '{3'd0, 8'sd0}},
    // fast band, then the fastest again right after
    '{'{qda_pkg::CMD_SAMPLE, 3'd1, 1'b1, 1'b1}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd1, 1'b0, 1'b1}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd1, 1'b1, 1'b0}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd1, 1'b0, 1'b0}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_TICK,   3'd3, 1'b0, 1'b1}, 8'd17, 1'b0, 1'b0, NO_STEP},
    // slow band on channel 2, medium band on channel 1
    '{'{qda_pkg::CMD_SAMPLE, 3'd2, 1'b1, 1'b1}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd2, 1'b0, 1'b1}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd1, 1'b1, 1'b1}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd1, 1'b0, 1'b1}, 8'd1, 1'b0, 1'b0, NO_STEP},
    // a history that is neither pattern
    '{'{qda_pkg::CMD_SAMPLE, 3'd4, 1'b1, 1'b1}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd4, 1'b1, 1'b1}, 8'd1, 1'b0, 1'b0, NO_STEP},
    // past every limit: unit step down
    '{'{qda_pkg::CMD_TICK,   3'd5, 1'b1, 1'b0}, 8'd8, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd3, 1'b1, 1'b0}, 8'd1, 1'b0, 1'b0, NO_STEP},
    '{'{qda_pkg::CMD_SAMPLE, 3'd3, 1'b0, 1'b0}, 8'd1, 1'b0, 1'b0, NO_STEP}
  };

  quadrature_decoder_with_acceleration_unit #(
    .CHANNELS   (CHANNELS),
    .TIME_WIDTH (TIME_W)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .channel        (channel),
    .phase_a        (phase_a),
    .phase_b        (phase_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .source_channel (source_channel),
    .step           (step)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // advance the model by one accepted word; returns whether a step word results
  function automatic logic decode_word(input qda_pkg::item_t w, output step_word_t res);
    logic [qda_pkg::HIST_W-1:0] h;
    logic [TIME_W-1:0]          elapsed;
    logic [qda_pkg::MAG_W-1:0]  mag;
    res = '0;
    if (w.cmd == qda_pkg::CMD_TICK) begin
      tick_now = tick_now + 1'b1;
      return 1'b0;
    end
    if (w.channel >= CHANNELS) return 1'b0;
    h = {hist_of[w.channel][1:0], w.phase_a, w.phase_b};
    hist_of[w.channel] = h;
    if (h != qda_pkg::HIST_DOWN && h != qda_pkg::HIST_UP) return 1'b0;
    // the counter wraps, so the difference is taken at full width
    elapsed = tick_now - stepped_at[w.channel];
    // first band that matches wins, even when the limits are out of order
    if (elapsed < cfg_now.fastest_limit)     mag = cfg_now.fastest_step;
    else if (elapsed < cfg_now.fast_limit)   mag = cfg_now.fast_step;
    else if (elapsed < cfg_now.medium_limit) mag = cfg_now.medium_step;
    else if (elapsed < cfg_now.slow_limit)   mag = cfg_now.slow_step;
    else                                     mag = 7'd1;
    // the step time moves even when a zero step size swallows the word
    stepped_at[w.channel] = tick_now;
    res.ch    = w.channel;
    res.value = (h == qda_pkg::HIST_DOWN) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    return mag != '0;
  endfunction

  // present one word, hold it until taken, then record what it should cause
  task automatic send_word(input qda_pkg::item_t w, input logic fixed,
                           input logic fixed_hit, input step_word_t fixed_res);
    int unsigned gap;
    step_word_t  res;
    logic        hit;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    cmd      <= w.cmd;
    channel  <= w.channel;
    phase_a  <= w.phase_a;
    phase_b  <= w.phase_b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    hit = decode_word(w, res);
    if (fixed) begin
      hit = fixed_hit;
      res = fixed_res;
    end
    if (hit) pending_steps.push_back(res);
  endtask

  // two samples set the whole history, so this steps from any prior state;
  // a broken turn slips a stray sample in between
  task automatic turn_encoder(input logic [qda_pkg::CH_W-1:0] ch, input logic down,
                              input logic broken);
    send_word('{qda_pkg::CMD_SAMPLE, ch, 1'b1, ~down}, 1'b0, 1'b0, NO_STEP);
    if (broken)
      send_word('{qda_pkg::CMD_SAMPLE, ch, 1'($urandom), 1'($urandom)},
                1'b0, 1'b0, NO_STEP);
    send_word('{qda_pkg::CMD_SAMPLE, ch, 1'b0, ~down}, 1'b0, 1'b0, NO_STEP);
  endtask

  // stop sending and wait for the decoder to go quiet
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input qda_pkg::cfg_reg_t idx,
                           input logic [qda_pkg::LIMIT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // step registers get junk in the unused upper data bits
  task automatic load_setting(input qda_pkg::cfg_t s);
    drain();
    write_reg(qda_pkg::REG_FASTEST_LIMIT, s.fastest_limit);
    write_reg(qda_pkg::REG_FAST_LIMIT,    s.fast_limit);
    write_reg(qda_pkg::REG_MEDIUM_LIMIT,  s.medium_limit);
    write_reg(qda_pkg::REG_SLOW_LIMIT,    s.slow_limit);
    write_reg(qda_pkg::REG_FASTEST_STEP,  {9'($urandom), s.fastest_step});
    write_reg(qda_pkg::REG_FAST_STEP,     {9'($urandom), s.fast_step});
    write_reg(qda_pkg::REG_MEDIUM_STEP,   {9'($urandom), s.medium_step});
    write_reg(qda_pkg::REG_SLOW_STEP,     {9'($urandom), s.slow_step});
    cfg_write <= 1'b0;
    cfg_now = s;
  endtask

  function automatic qda_pkg::cfg_t setting_for(input int p);
    qda_pkg::cfg_t s;
    case (p)
      // zero limits: every step is a unit step
      1: s = '{16'd0, 16'd0, 16'd0, 16'd0, 7'd127, 7'd127, 7'd127, 7'd127};
      // top limits: nearly everything is the largest step
      2: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127, 7'd1, 7'd1, 7'd1};
      // limits out of order
      3: s = '{16'd20, 16'd5, 16'd40, 16'd10, 7'd3, 7'd100, 7'd64, 7'd2};
      // zero step sizes swallow fastest and medium turns
      4: s = '{16'd7, 16'd15, 16'd22, 16'd30, 7'd0, 7'd16, 7'd0, 7'd4};
      5: s = '{16'd1, 16'd2, 16'd3, 16'd4, 7'd0, 7'd0, 7'd0, 7'd5};
      6, 7: begin
        s.fastest_limit = 16'($urandom_range(0, 48));
        s.fast_limit    = 16'($urandom_range(0, 48));
        s.medium_limit  = 16'($urandom_range(0, 48));
        s.slow_limit    = 16'($urandom_range(0, 48));
        s.fastest_step  = 7'($urandom_range(0, 127));
        s.fast_step     = 7'($urandom_range(0, 127));
        s.medium_step   = 7'($urandom_range(0, 127));
        s.slow_step     = 7'($urandom_range(0, 127));
      end
      default: s = qda_pkg::cfg_t'(CFG_W'({$urandom, $urandom, $urandom}));
    endcase
    return s;
  endfunction

  // mostly clean turns after a run of ticks, some noise words
  task automatic random_words(input int n);
    int sent;
    int k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 45) : $urandom_range(0, 12);
        repeat (k)
          send_word('{qda_pkg::CMD_TICK, 3'($urandom), 1'($urandom), 1'($urandom)},
                    1'b0, 1'b0, NO_STEP);
        turn_encoder(3'($urandom_range(0, CHANNELS - 1)), 1'($urandom),
                     $urandom_range(0, 7) == 0);
        sent += k + 2;
      end else begin
        send_word('{1'($urandom), 3'($urandom), 1'($urandom), 1'($urandom)},
                  1'b0, 1'b0, NO_STEP);
        sent++;
      end
    end
  endtask

  // result side: rotating stall pattern, reloaded now and then, off when calm
  always @(posedge clk) begin
    pace_count <= pace_count + 1;
    if (pace_count[8:0] == '0) calm <= ($urandom_range(0, 3) == 0);
    if (pace_count[5:0] == '0) begin
      case ($urandom_range(0, 2))
        0:       ready_pattern <= 16'($urandom | $urandom);
        1:       ready_pattern <= 16'($urandom & $urandom);
        default: ready_pattern <= 16'($urandom);
      endcase
    end else begin
      ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
    end
    out_ready <= calm || ready_pattern[0];
  end

  // every step word taken is held against the oldest expected one
  always @(posedge clk) begin : check_steps
    step_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: step word with none expected, actual channel %0d step %0d",
                 $time, source_channel, step);
        errors++;
      end else begin
        want = pending_steps.pop_front();
        if (source_channel !== want.ch) begin
          $display("%0t: source_channel expected %0d actual %0d",
                   $time, want.ch, source_channel);
          errors++;
        end
        if (step !== want.value) begin
          $display("%0t: step expected %0d actual %0d", $time, want.value, step);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    // model starts from the reset state and settings
    tick_now = '0;
    foreach (hist_of[i]) hist_of[i] = '0;
    foreach (stepped_at[i]) stepped_at[i] = '0;
    cfg_now.fastest_limit = 16'd7;
    cfg_now.fast_limit    = 16'd15;
    cfg_now.medium_limit  = 16'd22;
    cfg_now.slow_limit    = 16'd30;
    cfg_now.fastest_step  = 7'd24;
    cfg_now.fast_step     = 7'd16;
    cfg_now.medium_step   = 7'd8;
    cfg_now.slow_step     = 7'd4;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      repeat (dir_rows[i].reps)
        send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].hit,
                  dir_rows[i].result);
    random_words(RANDOM_WORDS);

    for (int p = 1; p < NUM_PHASES; p++) begin
      load_setting(setting_for(p));
      random_words(RANDOM_WORDS);
    end

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
